// ----- hw/rtl/tcce_pkg.sv -----
package tcce_pkg;

    typedef enum logic [1:0] {
        OP_PUT        = 2'd0,
        OP_SET_CURSOR = 2'd1,
        OP_CLEAR      = 2'd2,
        OP_READ_CELL  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_DRAIN,
        S_FILL,
        S_DONE
    } t_state;

    // cell layout: attribute in the high byte, character in the low byte
    typedef logic [15:0] t_cell;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    typedef struct packed {
        logic [7:0] text_color;
        logic [7:0] blank_color;
        logic       cursor_visible;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        logic        status;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [11:0] crtc_position;
        logic [7:0]  cell_char;
        logic [7:0]  cell_color;
    } t_result;

endpackage

// ----- hw/rtl/tcce_cell_ram.sv -----
module tcce_cell_ram #(
    parameter int DEPTH = 3200,
    parameter int AW    = 12
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  tcce_pkg::t_cell i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output tcce_pkg::t_cell o_rdata
);
    import tcce_pkg::*;

    t_cell r_mem [DEPTH];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/tcce_cfg_regs.sv -----
module tcce_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output tcce_pkg::t_cfg o_cfg
);
    import tcce_pkg::*;

    localparam logic [1:0] REG_TEXT_COLOR     = 2'd0;
    localparam logic [1:0] REG_BLANK_COLOR    = 2'd1;
    localparam logic [1:0] REG_CURSOR_VISIBLE = 2'd2;

    logic [7:0] r_text_color;
    logic [7:0] r_blank_color;
    logic       r_cursor_visible;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color     <= 8'd7;
            r_blank_color    <= 8'd7;
            r_cursor_visible <= 1'b1;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_TEXT_COLOR:     r_text_color     <= pwdata[7:0];
                REG_BLANK_COLOR:    r_blank_color    <= pwdata[7:0];
                REG_CURSOR_VISIBLE: r_cursor_visible <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_TEXT_COLOR:     prdata = {24'd0, r_text_color};
            REG_BLANK_COLOR:    prdata = {24'd0, r_blank_color};
            REG_CURSOR_VISIBLE: prdata = {31'd0, r_cursor_visible};
            default:            prdata = 32'd0;
        endcase
    end

    assign o_cfg.text_color     = r_text_color;
    assign o_cfg.blank_color    = r_blank_color;
    assign o_cfg.cursor_visible = r_cursor_visible;

endmodule

// ----- hw/rtl/tcce_engine.sv -----
module tcce_engine #(
    parameter int   SCREEN_ROWS    = 25,
    parameter int   SCREEN_COLUMNS = 80,
    localparam int  RW             = $clog2(SCREEN_ROWS),
    localparam int  CW             = $clog2(SCREEN_COLUMNS),
    localparam int  AW             = RW + CW
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  tcce_pkg::t_op    i_op,
    input  logic [7:0]       i_char,
    input  logic [4:0]       i_row,
    input  logic [6:0]       i_col,
    input  tcce_pkg::t_cfg   i_cfg,
    input  logic             i_slot_free,
    output tcce_pkg::t_result o_res,
    output logic             o_mem_we,
    output logic [AW-1:0]    o_mem_waddr,
    output tcce_pkg::t_cell  o_mem_wdata,
    output logic [AW-1:0]    o_mem_raddr,
    input  tcce_pkg::t_cell  i_mem_rdata
);
    import tcce_pkg::*;

    localparam logic [RW-1:0] LAST_ROW    = RW'(SCREEN_ROWS - 1);
    localparam logic [CW-1:0] LAST_COL    = CW'(SCREEN_COLUMNS - 1);
    localparam logic [5:0]    ROW_LIM     = 6'(SCREEN_ROWS);
    localparam logic [7:0]    COL_LIM     = 8'(SCREEN_COLUMNS);
    localparam logic [11:0]   CRTC_HIDDEN = 12'((SCREEN_ROWS + 1) * SCREEN_COLUMNS);

    t_state        r_state, n_state;
    logic [RW-1:0] r_cur_row, n_cur_row;
    logic [CW-1:0] r_cur_col, n_cur_col;
    logic [RW-1:0] r_sw_row, n_sw_row;
    logic [CW-1:0] r_sw_col, n_sw_col;
    logic          r_cp_valid, n_cp_valid;
    logic [AW-1:0] r_cp_addr, n_cp_addr;
    logic          r_status, n_status;
    t_cell         r_cell, n_cell;

    logic          w_take;
    logic          w_in_range;
    logic          w_last_row, w_last_col, w_home;
    logic          w_sw_end_col, w_sw_end;
    logic          w_plain_char;
    logic          w_scroll_req;
    logic [RW-1:0] w_adv_row;
    logic [CW-1:0] w_adv_col;
    logic [12:0]   w_lin;
    t_cell         w_blank;

    assign w_take       = i_valid && (r_state == S_IDLE);
    assign w_in_range   = ({1'b0, i_row} < ROW_LIM) && ({1'b0, i_col} < COL_LIM);
    assign w_last_row   = (r_cur_row == LAST_ROW);
    assign w_last_col   = (r_cur_col == LAST_COL);
    assign w_home       = (r_cur_row == '0) && (r_cur_col == '0);
    assign w_sw_end_col = (r_sw_col == LAST_COL);
    assign w_sw_end     = w_sw_end_col && (r_sw_row == LAST_ROW);
    assign w_plain_char = (i_char != CH_NEWLINE) && (i_char != CH_RETURN)
                          && (i_char != CH_BACKSPACE);
    // a newline on the bottom row or a character in the last cell scrolls
    assign w_scroll_req = ((i_char == CH_NEWLINE) && w_last_row)
                          || (w_plain_char && w_last_row && w_last_col);
    assign w_blank      = {i_cfg.blank_color, CH_SPACE};

    // sweep step in row-major order over the visible cells
    always_comb begin
        if (w_sw_end_col) begin
            w_adv_col = '0;
            w_adv_row = (r_sw_row == LAST_ROW) ? '0 : r_sw_row + 1'b1;
        end else begin
            w_adv_col = r_sw_col + 1'b1;
            w_adv_row = r_sw_row;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (w_sw_end) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_take) begin
                    unique case (i_op)
                        OP_PUT:        n_state = w_scroll_req ? S_SCROLL : S_DONE;
                        OP_SET_CURSOR: n_state = S_DONE;
                        OP_CLEAR:      n_state = S_FILL;
                        OP_READ_CELL:  n_state = w_in_range ? S_READ : S_DONE;
                        default:       n_state = S_DONE;
                    endcase
                end
            end
            S_READ:   n_state = S_DONE;
            S_SCROLL: begin
                if (w_sw_end) n_state = S_DRAIN;
            end
            S_DRAIN:  n_state = S_FILL;
            S_FILL: begin
                if (w_sw_end) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_slot_free) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // cursor, sweep and memory port
    always_comb begin
        n_cur_row   = r_cur_row;
        n_cur_col   = r_cur_col;
        n_sw_row    = r_sw_row;
        n_sw_col    = r_sw_col;
        n_cp_valid  = 1'b0;
        n_cp_addr   = {r_sw_row - 1'b1, r_sw_col};
        n_status    = r_status;
        n_cell      = r_cell;
        o_mem_we    = 1'b0;
        o_mem_waddr = {r_sw_row, r_sw_col};
        o_mem_wdata = w_blank;
        o_mem_raddr = {r_sw_row, r_sw_col};
        unique case (r_state)
            S_INIT: begin
                o_mem_we    = 1'b1;
                o_mem_wdata = '0;
                n_sw_row    = w_adv_row;
                n_sw_col    = w_adv_col;
            end
            S_IDLE: begin
                o_mem_raddr = {i_row[RW-1:0], i_col[CW-1:0]};
                if (w_take) begin
                    n_status = 1'b0;
                    n_cell   = '0;
                    n_sw_row = '0;
                    n_sw_col = '0;
                    unique case (i_op)
                        OP_PUT: begin
                            if (i_char == CH_NEWLINE) begin
                                n_cur_col = '0;
                                if (w_last_row) begin
                                    n_sw_row = RW'(1);
                                end else begin
                                    n_cur_row = r_cur_row + 1'b1;
                                end
                            end else if (i_char == CH_RETURN) begin
                                n_cur_col = '0;
                            end else if (i_char == CH_BACKSPACE) begin
                                if (!w_home) begin
                                    o_mem_we = 1'b1;
                                    if (r_cur_col == '0) begin
                                        n_cur_row = r_cur_row - 1'b1;
                                        n_cur_col = LAST_COL;
                                    end else begin
                                        n_cur_col = r_cur_col - 1'b1;
                                    end
                                    o_mem_waddr = {n_cur_row, n_cur_col};
                                end
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = {r_cur_row, r_cur_col};
                                o_mem_wdata = {i_cfg.text_color, i_char};
                                if (w_last_col) begin
                                    n_cur_col = '0;
                                    if (w_last_row) begin
                                        n_sw_row = RW'(1);
                                    end else begin
                                        n_cur_row = r_cur_row + 1'b1;
                                    end
                                end else begin
                                    n_cur_col = r_cur_col + 1'b1;
                                end
                            end
                        end
                        OP_SET_CURSOR: begin
                            if (w_in_range) begin
                                n_cur_row = i_row[RW-1:0];
                                n_cur_col = i_col[CW-1:0];
                            end else begin
                                n_status = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_cur_row = '0;
                            n_cur_col = '0;
                        end
                        OP_READ_CELL: begin
                            if (!w_in_range) n_status = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                n_cell = i_mem_rdata;
            end
            S_SCROLL: begin
                // read one row down, write the returned cell one row up in the next cycle
                n_cp_valid  = 1'b1;
                o_mem_we    = r_cp_valid;
                o_mem_waddr = r_cp_addr;
                o_mem_wdata = i_mem_rdata;
                n_sw_row    = w_sw_end ? LAST_ROW : w_adv_row;
                n_sw_col    = w_adv_col;
            end
            S_DRAIN: begin
                o_mem_we    = r_cp_valid;
                o_mem_waddr = r_cp_addr;
                o_mem_wdata = i_mem_rdata;
            end
            S_FILL: begin
                o_mem_we = 1'b1;
                n_sw_row = w_adv_row;
                n_sw_col = w_adv_col;
            end
            S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_cur_row  <= '0;
            r_cur_col  <= '0;
            r_sw_row   <= '0;
            r_sw_col   <= '0;
            r_cp_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cur_row  <= n_cur_row;
            r_cur_col  <= n_cur_col;
            r_sw_row   <= n_sw_row;
            r_sw_col   <= n_sw_col;
            r_cp_valid <= n_cp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_addr <= n_cp_addr;
        r_status  <= n_status;
        r_cell    <= n_cell;
    end

    assign w_lin = 13'(r_cur_row) * 13'(SCREEN_COLUMNS) + 13'(r_cur_col);

    // outputs
    always_comb begin
        o_ready             = (r_state == S_IDLE);
        o_res.valid         = (r_state == S_DONE);
        o_res.status        = r_status;
        o_res.cursor_row    = 5'(r_cur_row);
        o_res.cursor_col    = 7'(r_cur_col);
        o_res.crtc_position = i_cfg.cursor_visible ? w_lin[11:0] : CRTC_HIDDEN;
        o_res.cell_char     = r_cell[7:0];
        o_res.cell_color    = r_cell[15:8];
    end

`ifndef ASSERT_OFF
    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_row <= LAST_ROW) && (r_cur_col <= LAST_COL))
        else $error("cursor left the screen");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && i_slot_free |=> !o_res.valid)
        else $error("result offered twice");

    a_take_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> !o_ready)
        else $error("new item taken while one is in progress");

    a_copy_in_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_valid |-> (r_state == S_SCROLL || r_state == S_DRAIN))
        else $error("scroll copy write outside scroll");
`endif

endmodule

// ----- hw/rtl/text_console_char_engine_unit.sv -----
// Text console engine: a character/attribute cell store driven by a command stream.
// s_* channel: one command per transfer, s_tuser holds the operation (put
// character, set cursor, clear screen, read cell), s_tdata its arguments.
// m_* channel: one result per command with status, cursor, CRTC position and
// the cell read back (zero for other operations).
// The APB port sets text color, blank color and cursor visibility; write it
// only while no command is in flight.
// A put character, carriage return, set cursor or failed read goes straight to
// the result; a cell read first reads the memory. A scroll (newline on the
// last row or a character in the last cell) copies the lower rows one row up
// and then fills one row; clear fills every visible cell. Each step is one
// access on the single write port of the cell memory.
// After reset the engine clears every visible cell to zero with s_tready low;
// config writes still work.
// The result sits in an output register, so the engine finishes and takes the
// next command while m_tready is low, and only holds when the register is full.
module text_console_char_engine_unit #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code[7:0], row[12:8], col[19:13], zero pad
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[0], cursor_row[5:1], cursor_col[12:6], crtc_position[24:13],
    // cell_char[32:25], cell_color[40:33], zero pad
    output logic [47:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tcce_pkg::*;

    localparam int RW    = $clog2(SCREEN_ROWS);
    localparam int CW    = $clog2(SCREEN_COLUMNS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = SCREEN_ROWS * (2 ** CW);

    t_cfg          w_cfg;
    t_result       w_res;
    logic          w_slot_free;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;
    t_cell         w_wdata;
    t_cell         w_rdata;
    logic          r_out_valid;
    logic [47:0]   r_out_data;

    tcce_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tcce_engine #(
        .SCREEN_ROWS    (SCREEN_ROWS),
        .SCREEN_COLUMNS (SCREEN_COLUMNS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_tvalid),
        .o_ready     (s_tready),
        .i_op        (t_op'(s_tuser)),
        .i_char      (s_tdata[7:0]),
        .i_row       (s_tdata[12:8]),
        .i_col       (s_tdata[19:13]),
        .i_cfg       (w_cfg),
        .i_slot_free (w_slot_free),
        .o_res       (w_res),
        .o_mem_we    (w_we),
        .o_mem_waddr (w_waddr),
        .o_mem_wdata (w_wdata),
        .o_mem_raddr (w_raddr),
        .i_mem_rdata (w_rdata)
    );

    tcce_cell_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_slot_free = !r_out_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.valid && w_slot_free) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.valid && w_slot_free) begin
            r_out_data <= {7'd0, w_res.cell_color, w_res.cell_char, w_res.crtc_position,
                           w_res.cursor_col, w_res.cursor_row, w_res.status};
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

endmodule
